/* src/nsrm_pkg.sv */
// Package for the n-step replay memory: sizes, record type, controller states.
// No dependencies.
`timescale 1ns / 1ps
package nsrm_pkg;
  localparam int MemDepth = 1024;
  localparam int MemAw = $clog2(MemDepth);
  localparam int CntW = $clog2(MemDepth + 1);
  localparam int EpDepth = 256;
  localparam int EpAw = $clog2(EpDepth);
  localparam int LenW = $clog2(EpDepth + 1);
  localparam int SumW = 40;
  localparam int RecW = 16 * 4 + SumW + 1;
  localparam int EpW = 16 + 16 + 32;
  localparam int RandW = 32;

  localparam logic CFG_N_STEP = 1'b0;
  localparam logic CFG_BATCH = 1'b1;

  typedef struct packed {
    logic [15:0] graph;
    logic [15:0] state;
    logic [15:0] action;
    logic [SumW-1:0] ret;
    logic [15:0] next_state;
    logic terminal;
  } rec_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM_RD, ST_SUM_WR, ST_EM_RD, ST_EM_AH, ST_EM_WR,
    ST_DIV, ST_SMP_RD, ST_SMP_OUT
  } state_t;
endpackage

/* src/nsrm_ram.sv */
// Generic single-port-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps
module nsrm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* src/nsrm_mod.sv */
// Restoring divider remainder: value mod divisor, one quotient bit a cycle.
// Depends on nsrm_pkg.
`timescale 1ns / 1ps
module nsrm_mod
  import nsrm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [RandW-1:0] value,
  input  logic [CntW-1:0]  divisor,
  output logic             done,
  output logic [MemAw-1:0] rem
);
  logic [RandW-1:0] sh;
  logic [CntW:0] acc;
  logic [5:0] cnt;
  logic busy;
  logic [CntW:0] trial;

  assign trial = {acc[CntW-1:0], sh[RandW-1]};
  assign rem = acc[MemAw-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt <= 6'(RandW);
        sh <= value;
        acc <= '0;
      end else if (busy) begin
        sh <= {sh[RandW-2:0], 1'b0};
        acc <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* src/nstep_replay_memory_unit.sv */
// Top level of the n-step replay memory: controller, episode and record RAMs.
// Depends on nsrm_pkg, nsrm_ram, nsrm_mod.
`timescale 1ns / 1ps
// A load item (op 0) holds busy for one cycle, so a following item is taken
// only once busy has dropped. A load with last_step high also runs the
// episode flush: a backward suffix-sum pass through the episode RAM that
// reads each stored step and writes its suffix sum, then a pass that emits
// records (read step, read step n ahead, write record) and ends in a
// closing state; busy stays high until it is over. A sample item (op 1)
// runs a bit-serial modulo then a record RAM read; done rises in the same
// edge that drops busy. With too few records the modulo result is not
// awaited, and done rises with status 1 and zero fields.
// The receiver cannot stall: done is a one-cycle strobe.
module nstep_replay_memory_unit
  import nsrm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        op,
  input  logic [15:0] graph_id,
  input  logic [15:0] state_handle,
  input  logic [15:0] action,
  input  logic signed [31:0] reward,
  input  logic        last_step,
  input  logic [15:0] final_state_handle,
  input  logic [31:0] random_value,
  output logic        done,
  output logic [15:0] out_graph_id,
  output logic [15:0] out_state_handle,
  output logic [15:0] out_action,
  output logic signed [39:0] out_return,
  output logic [15:0] out_next_state_handle,
  output logic        out_terminal,
  output logic        status
);
  state_t state, state_next;
  logic [8:0] n_step;
  logic [10:0] min_fill;
  logic [LenW-1:0] ep_length;
  logic [15:0] ep_graph, final_h;
  logic [MemAw-1:0] write_pointer;
  logic [CntW-1:0] stored_count;
  logic [LenW-1:0] idx;           // walk index
  logic [SumW-1:0] run_sum;       // running suffix sum
  logic [EpW-1:0] cur_ep;         // step i contents
  logic [SumW-1:0] cur_sum;
  logic busy_r;

  // Episode RAM: state, action, reward; suffix RAM separate.
  logic ep_we;
  logic [EpAw-1:0] ep_wa, ep_ra;
  logic [EpW-1:0] ep_wd, ep_rd;
  logic sx_we;
  logic [EpAw-1:0] sx_wa, sx_ra;
  logic [SumW-1:0] sx_wd, sx_rd;
  logic rec_we;
  logic [MemAw-1:0] rec_ra;
  rec_t rec_wd, rec_rd;
  logic mod_go, mod_done;
  logic [MemAw-1:0] mod_rem;
  logic accept;
  logic [LenW-1:0] ahead;
  logic ahead_ok;
  logic [SumW-1:0] rew_ext;

  nsrm_ram #(.Width(EpW), .Depth(EpDepth)) u_ep (
    .clk, .we(ep_we), .waddr(ep_wa), .wdata(ep_wd), .raddr(ep_ra), .rdata(ep_rd));
  nsrm_ram #(.Width(SumW), .Depth(EpDepth)) u_sx (
    .clk, .we(sx_we), .waddr(sx_wa), .wdata(sx_wd),
    .raddr(sx_ra), .rdata(sx_rd));
  nsrm_ram #(.Width(RecW), .Depth(MemDepth)) u_rec (
    .clk, .we(rec_we), .waddr(write_pointer), .wdata(rec_wd),
    .raddr(rec_ra), .rdata(rec_rd));
  // The modulo samples random_value at the accepting edge.
  nsrm_mod u_mod (
    .clk, .rst, .go(mod_go), .value(random_value), .divisor(stored_count),
    .done(mod_done), .rem(mod_rem));

  assign accept = start && !busy;
  assign busy = busy_r;
  assign ahead = idx + LenW'(n_step);
  assign ahead_ok = ({1'b0, idx} + {1'b0, n_step}) < {1'b0, ep_length};
  assign rew_ext = {{(SumW-32){ep_rd[31]}}, ep_rd[31:0]};

  // Suffix pass reads ep[idx-1]; emit reads ep[idx], then ep[ahead].
  always_comb begin
    ep_we = 1'b0;
    ep_wa = ep_length[EpAw-1:0];
    ep_wd = {state_handle, action, reward};
    ep_ra = idx[EpAw-1:0];
    sx_ra = idx[EpAw-1:0];
    sx_we = 1'b0;
    sx_wa = EpAw'(idx - 1'b1);
    sx_wd = run_sum + rew_ext;
    rec_we = 1'b0;
    mod_go = 1'b0;
    rec_ra = mod_rem;
    rec_wd.graph = ep_graph;
    rec_wd.state = cur_ep[63:48];
    rec_wd.action = cur_ep[47:32];
    rec_wd.ret = ahead_ok ? cur_sum - sx_rd : cur_sum;
    rec_wd.next_state = ahead_ok ? ep_rd[63:48] : final_h;
    rec_wd.terminal = !ahead_ok;
    if (n_step == 9'd0) begin
      rec_wd.ret = '0;
      rec_wd.next_state = cur_ep[63:48];
      rec_wd.terminal = 1'b0;
    end
    case (state)
      ST_IDLE: begin
        ep_we = accept && !op && (ep_length < LenW'(EpDepth));
        mod_go = accept && op;
      end
      ST_SUM_RD: ep_ra = EpAw'(idx - 1'b1);
      ST_SUM_WR: sx_we = 1'b1;
      ST_EM_AH: begin
        ep_ra = ahead[EpAw-1:0];
        sx_ra = ahead[EpAw-1:0];
      end
      ST_EM_WR: rec_we = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (accept) begin
          if (op) state_next = ST_DIV;
          else if (last_step) state_next = ST_SUM_RD;
        end
      ST_SUM_RD: state_next = (idx == '0) ? ST_IDLE : ST_SUM_WR;
      ST_SUM_WR: state_next = (idx == LenW'(1)) ? ST_EM_RD : ST_SUM_RD;
      ST_EM_RD: state_next = (idx == ep_length) ? ST_IDLE : ST_EM_AH;
      ST_EM_AH: state_next = ST_EM_WR;
      ST_EM_WR: state_next = ST_EM_RD;
      ST_DIV:
        if (stored_count == '0 || stored_count < min_fill) state_next = ST_SMP_OUT;
        else if (mod_done) state_next = ST_SMP_RD;
      ST_SMP_RD: state_next = ST_SMP_OUT;
      ST_SMP_OUT: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n_step <= 9'd1;
      min_fill <= 11'd1;
      ep_length <= '0;
      ep_graph <= '0;
      write_pointer <= '0;
      stored_count <= '0;
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      busy_r <= (state_next != ST_IDLE) || accept;
      if (cfg_we) begin
        if (cfg_index == CFG_N_STEP) n_step <= cfg_data[8:0];
        else min_fill <= cfg_data;
      end
      case (state)
        ST_IDLE:
          if (accept) begin
            if (!op) begin
              ep_graph <= graph_id;
              final_h <= final_state_handle;
              if (ep_length < LenW'(EpDepth)) begin
                ep_length <= ep_length + 1'b1;
                idx <= ep_length + 1'b1;
              end else idx <= ep_length;
              run_sum <= '0;
            end
          end
        ST_SUM_RD: if (idx == '0) ep_length <= '0;
        ST_SUM_WR: begin
          // write happens this cycle at idx-1
          idx <= idx - 1'b1;
        end
        ST_EM_RD: begin
          if (idx == ep_length) ep_length <= '0;
        end
        ST_EM_AH: begin
          cur_ep <= ep_rd;
          cur_sum <= sx_rd;
        end
        ST_EM_WR: begin
          idx <= idx + 1'b1;
          write_pointer <= (write_pointer == MemAw'(MemDepth - 1)) ? '0
                           : write_pointer + 1'b1;
          if (stored_count < CntW'(write_pointer) + 1'b1)
            stored_count <= CntW'(write_pointer) + 1'b1;
        end
        ST_SMP_RD: ;
        ST_SMP_OUT: begin
          done <= 1'b1;
          status <= (stored_count == '0) || (stored_count < min_fill);
          if ((stored_count == '0) || (stored_count < min_fill)) begin
            {out_graph_id, out_state_handle, out_action} <= '0;
            out_return <= '0;
            out_next_state_handle <= '0;
            out_terminal <= 1'b0;
          end else begin
            out_graph_id <= rec_rd.graph;
            out_state_handle <= rec_rd.state;
            out_action <= rec_rd.action;
            out_return <= rec_rd.ret;
            out_next_state_handle <= rec_rd.next_state;
            out_terminal <= rec_rd.terminal;
          end
        end
        default: ;
      endcase
      // Suffix pass: run_sum accumulates reward idx-1 read in SUM_RD.
      if (state == ST_SUM_WR) begin
        run_sum <= run_sum + rew_ext;
      end
    end
  end
endmodule

/* bench/tb.sv */
// Self-checking bench for nstep_replay_memory_unit: loads episodes, samples records.
// Depends on nsrm_pkg and the RTL under src/.
`timescale 1ns / 1ps
module tb
  import nsrm_pkg::*;
();

  // One sampled record as the block should show it.
  typedef struct {
    logic [15:0] graph;
    logic [15:0] state;
    logic [15:0] action;
    logic [39:0] ret;
    logic [15:0] next_state;
    logic        terminal;
    logic        too_few;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start, cfg_we, cfg_index, op, last_step;
  logic [10:0] cfg_data;
  logic [15:0] graph_id, state_handle, action, final_state_handle;
  logic signed [31:0] reward;
  logic [31:0] random_value;
  logic busy, done, out_terminal, status;
  logic [15:0] out_graph_id, out_state_handle, out_action, out_next_state_handle;
  logic signed [39:0] out_return;

  always #2 clk = ~clk;

  nstep_replay_memory_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op(op), .graph_id(graph_id), .state_handle(state_handle), .action(action),
    .reward(reward), .last_step(last_step), .final_state_handle(final_state_handle),
    .random_value(random_value), .done(done), .out_graph_id(out_graph_id),
    .out_state_handle(out_state_handle), .out_action(out_action),
    .out_return(out_return), .out_next_state_handle(out_next_state_handle),
    .out_terminal(out_terminal), .status(status)
  );

  // Predictor state: configuration, record ring, open episode.
  logic [8:0]  lookahead;
  logic [10:0] min_records;
  logic [15:0] ring_graph [MemDepth];
  logic [15:0] ring_state [MemDepth];
  logic [15:0] ring_action [MemDepth];
  logic [39:0] ring_return [MemDepth];
  logic [15:0] ring_next [MemDepth];
  logic        ring_term [MemDepth];
  logic [15:0] step_state [EpDepth];
  logic [15:0] step_action [EpDepth];
  logic [31:0] step_reward [EpDepth];
  logic [39:0] tail_sum [EpDepth];
  int          steps_held;
  logic [15:0] episode_graph;
  int          wr_ptr;
  int          rec_count;

  sample_t pending_samples[$];
  int      errors = 0;
  bit      allow_idle = 1'b1;

  function automatic void store_record(logic [15:0] s, logic [15:0] a, logic [39:0] r,
                                       logic [15:0] nx, logic t);
    ring_graph[wr_ptr] = episode_graph;
    ring_state[wr_ptr] = s;
    ring_action[wr_ptr] = a;
    ring_return[wr_ptr] = r;
    ring_next[wr_ptr] = nx;
    ring_term[wr_ptr] = t;
    if (rec_count < wr_ptr + 1) rec_count = wr_ptr + 1;
    wr_ptr = (wr_ptr + 1) % MemDepth;
  endfunction

  // Backward suffix sums, then one record per held step.
  function automatic void close_episode(logic [15:0] final_handle);
    int ahead;
    if (steps_held == 0) return;
    tail_sum[steps_held-1] = {{8{step_reward[steps_held-1][31]}}, step_reward[steps_held-1]};
    for (int i = steps_held - 1; i > 0; i--)
      tail_sum[i-1] = tail_sum[i] + {{8{step_reward[i-1][31]}}, step_reward[i-1]};
    for (int i = 0; i < steps_held; i++) begin
      ahead = i + int'(lookahead);
      if (ahead >= steps_held)
        store_record(step_state[i], step_action[i], tail_sum[i], final_handle, 1'b1);
      else
        store_record(step_state[i], step_action[i], tail_sum[i] - tail_sum[ahead],
                     step_state[ahead], 1'b0);
    end
    steps_held = 0;
  endfunction

  // Update predictor on an accepted item; queue a result for samples.
  function automatic void predict_item();
    sample_t e;
    int idx;
    if (op == 1'b0) begin
      episode_graph = graph_id;
      if (steps_held < EpDepth) begin
        step_state[steps_held] = state_handle;
        step_action[steps_held] = action;
        step_reward[steps_held] = reward;
        steps_held++;
      end
      if (last_step) close_episode(final_state_handle);
    end else begin
      e = '{default: '0};
      if (rec_count == 0 || rec_count < int'(min_records)) begin
        e.too_few = 1'b1;
      end else begin
        idx = int'(random_value % 32'(rec_count));
        e.graph = ring_graph[idx];
        e.state = ring_state[idx];
        e.action = ring_action[idx];
        e.ret = ring_return[idx];
        e.next_state = ring_next[idx];
        e.terminal = ring_term[idx];
      end
      pending_samples.push_back(e);
    end
  endfunction

  // Drive one item and hold it until the block takes it.
  task automatic send_item(logic o, logic [15:0] g, logic [15:0] s, logic [15:0] a,
                           logic [31:0] r, logic l, logic [15:0] f, logic [31:0] rv);
    start <= 1'b1;
    op <= o; graph_id <= g; state_handle <= s; action <= a;
    reward <= r; last_step <= l; final_state_handle <= f; random_value <= rv;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item();
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load_step(logic l);
    send_item(1'b0, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, l,
              16'($urandom), $urandom);
  endtask

  task automatic sample(logic [31:0] rv);
    send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, 1'($urandom),
              16'($urandom), rv);
  endtask

  // Hold off until every sample has answered and the flush is over.
  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while ((pending_samples.size() != 0 || busy) && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [10:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_N_STEP) lookahead = val[8:0];
    else min_records = val;
  endtask

  // Result checker: done is a one-cycle strobe.
  task automatic check_field(string name, logic [39:0] exp_v, logic [39:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    sample_t e;
    if (!rst && done) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected result, expected none, got graph %h", $time,
                 out_graph_id);
        errors++;
      end else begin
        e = pending_samples.pop_front();
        check_field("status", e.too_few, status);
        check_field("graph", e.graph, out_graph_id);
        check_field("state", e.state, out_state_handle);
        check_field("action", e.action, out_action);
        check_field("return", e.ret, out_return);
        check_field("next_state", e.next_state, out_next_state_handle);
        check_field("terminal", e.terminal, out_terminal);
      end
    end
  end

  // Empty memory, small hand-built episodes, extreme rewards, n_step 0.
  task automatic test_directed();
    sample(32'h0);
    write_cfg(CFG_BATCH, 11'd0);
    sample(32'hFFFF_FFFF);
    send_item(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 32'h7FFF_FFFF, 1'b0, 16'h0, 32'h0);
    send_item(1'b0, 16'h0000, 16'hFFFF, 16'h0000, 32'h8000_0000, 1'b0, 16'h0, 32'h0);
    send_item(1'b0, 16'hA5A5, 16'h1234, 16'h5678, 32'hFFFF_FFFF, 1'b1, 16'hBEEF, 32'h0);
    for (int i = 0; i < 3; i++) sample(32'(i));
    write_cfg(CFG_N_STEP, 9'd0);
    send_item(1'b0, 16'h0001, 16'h1111, 16'h2222, 32'h0001_0000, 1'b0, 16'h0, 32'h0);
    send_item(1'b0, 16'h0002, 16'h3333, 16'h4444, 32'h8000_0000, 1'b1, 16'hFFFF, 32'h0);
    sample(32'd3); sample(32'd4);
    write_cfg(CFG_N_STEP, 9'd256);
    for (int i = 0; i < 4; i++) load_step(i == 3);
    sample(32'd5); sample(32'hFFFF_FFFF);
    write_cfg(CFG_BATCH, 11'd2047);
    sample($urandom);
  endtask

  // More steps than the episode store holds; the extras are dropped.
  task automatic test_episode_overflow();
    write_cfg(CFG_N_STEP, 9'd3);
    write_cfg(CFG_BATCH, 11'd1);
    for (int i = 0; i < EpDepth + 3; i++)
      send_item(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, i == EpDepth + 2,
                16'($urandom), 32'h0);
    for (int i = 0; i < 8; i++) sample($urandom);
  endtask

  // Random episodes with samples in between, several register settings.
  task automatic test_random_phase(logic [8:0] n, logic [10:0] b, int items);
    int sent, len;
    write_cfg(CFG_N_STEP, n);
    write_cfg(CFG_BATCH, b);
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 2) == 0) begin
        sample(($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom);
        sent++;
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) load_step(i == len - 1);
        sent += len;
      end
    end
  endtask

  initial begin
    int guard;
    start <= 1'b0; cfg_we <= 1'b0; cfg_index <= CFG_N_STEP; cfg_data <= '0;
    op <= 1'b0; graph_id <= '0; state_handle <= '0; action <= '0; reward <= '0;
    last_step <= 1'b0; final_state_handle <= '0; random_value <= '0;
    lookahead = 9'd1; min_records = 11'd1;
    steps_held = 0; episode_graph = '0; wr_ptr = 0; rec_count = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_episode_overflow();
    test_random_phase(9'd1, 11'd1, 190);
    test_random_phase(9'd0, 11'd1024, 190);
    test_random_phase(9'd511, 11'd0, 190);
    test_random_phase(9'd5, 11'd64, 190);
    allow_idle = 1'b0;
    test_random_phase(9'd2, 11'd1, 190);

    start <= 1'b0;
    guard = 0;
    while (pending_samples.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_samples.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
